// ----- src/pce_pkg.sv -----
// pce_pkg: types and constants for the pixel color effect pipeline
// effect codes, sepia coefficients (unsigned Q0.16) and internal widths
// no dependencies
package pce_pkg;

    // effect selector codes
    typedef enum logic [2:0] {
        EFF_RED   = 3'd0,
        EFF_GREEN = 3'd1,
        EFF_BLUE  = 3'd2,
        EFF_MEAN  = 3'd3,
        EFF_MAX   = 3'd4,
        EFF_SEPIA = 3'd5
    } t_effect;

    localparam int CH_W   = 8;
    localparam int COEF_W = 16;
    localparam int PROD_W = CH_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int TRI_W  = CH_W + 2;

    // reciprocal of three: floor(s * 683 / 2048) == s / 3 for s <= 765
    localparam int          RECIP_SHIFT = 11;
    localparam logic [10:0] RECIP3      = 11'd683;
    localparam int          MEAN_PROD_W = TRI_W + 11;

    typedef logic [COEF_W-1:0] t_coef;

    // sepia coefficients, coefficient * 65536 rounded to nearest
    localparam t_coef SEP_RR = 16'd25756;
    localparam t_coef SEP_RG = 16'd50397;
    localparam t_coef SEP_RB = 16'd12386;
    localparam t_coef SEP_GR = 16'd22872;
    localparam t_coef SEP_GG = 16'd44958;
    localparam t_coef SEP_GB = 16'd11010;
    localparam t_coef SEP_BR = 16'd17826;
    localparam t_coef SEP_BG = 16'd34996;
    localparam t_coef SEP_BB = 16'd8585;

    // original pixel travelling along the pipeline
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_pixel;

endpackage

// ----- src/pixel_color_effect.sv -----
// pixel_color_effect: three-stage pipeline applying a selectable color effect
// to an 8-bit RGB stream; depends on pce_pkg
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+-----------------------------------------------
//  pixel in  | in  | i_in_valid / o_in_ready   | i_in_red, i_in_green, i_in_blue, i_in_last
//  pixel out | out | o_out_valid / i_out_ready | o_out_red, o_out_green, o_out_blue, o_out_last
//  config    | in  | i_cfg_valid / o_cfg_ready | i_cfg_data (effect select)
//
// one pixel per clock sustained while the output is ready; a pixel passes the three
// register stages in order before output valid rises: stage 1 holds the sepia products,
// stage 2 the product sums and the mean by reciprocal multiply, stage 3 saturation
// and effect select.
// synchronous active-low reset clears the valid bits and sets the effect to red only.
// each stage moves when it is empty or the stage after it moves, so a stall at
// the output fills bubbles first and nothing is dropped or repeated.
module pixel_color_effect
    import pce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data,
    // input pixel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CH_W-1:0]   i_in_red,
    input  logic [CH_W-1:0]   i_in_green,
    input  logic [CH_W-1:0]   i_in_blue,
    input  logic              i_in_last,
    // output pixel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CH_W-1:0]   o_out_red,
    output logic [CH_W-1:0]   o_out_green,
    output logic [CH_W-1:0]   o_out_blue,
    output logic              o_out_last
);

    // effect register
    logic [2:0] r_effect;

    // stage 1: products, channel sum, channel max
    logic              r_s1_valid;
    t_pixel            r_s1_pix;
    logic [2:0]        r_s1_eff;
    logic [PROD_W-1:0] r_s1_rr, r_s1_rg, r_s1_rb;
    logic [PROD_W-1:0] r_s1_gr, r_s1_gg, r_s1_gb;
    logic [PROD_W-1:0] r_s1_br, r_s1_bg, r_s1_bb;
    logic [TRI_W-1:0]  r_s1_tri;
    logic [CH_W-1:0]   r_s1_max;

    // stage 2: product sums, mean, max
    logic                   r_s2_valid;
    t_pixel                 r_s2_pix;
    logic [2:0]             r_s2_eff;
    logic [SUM_W-1:0]       r_s2_sum_r, r_s2_sum_g, r_s2_sum_b;
    logic [CH_W-1:0]        r_s2_mean;
    logic [CH_W-1:0]        r_s2_max;

    // stage 3: output register
    logic              r_s3_valid;
    t_pixel            r_s3_pix;

    logic adv_s1, adv_s2, adv_s3;
    logic in_xfer;

    logic [CH_W-1:0]        in_max_rg;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [SUM_W-CH_W-COEF_W+CH_W-1:0] sep_r_hi, sep_g_hi, sep_b_hi;
    logic [CH_W-1:0]        sat_r, sat_g, sat_b;
    t_pixel                 n_s3_pix;

    // stall chain: a stage moves when empty or when its successor moves
    assign adv_s3      = !r_s3_valid || i_out_ready;
    assign adv_s2      = !r_s2_valid || adv_s3;
    assign adv_s1      = !r_s1_valid || adv_s2;
    assign o_in_ready  = adv_s1;
    assign in_xfer     = i_in_valid && adv_s1;
    assign o_cfg_ready = 1'b1;

    // configuration transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect <= EFF_RED;
        end else if (i_cfg_valid) begin
            r_effect <= i_cfg_data;
        end
    end

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    assign in_max_rg = (i_in_red > i_in_green) ? i_in_red : i_in_green;

    // stage 1 payload: nine coefficient products, channel sum and channel max
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix <= '{red: i_in_red, green: i_in_green, blue: i_in_blue, last: i_in_last};
            r_s1_eff <= r_effect;
            r_s1_rr  <= PROD_W'(i_in_red)   * PROD_W'(SEP_RR);
            r_s1_rg  <= PROD_W'(i_in_green) * PROD_W'(SEP_RG);
            r_s1_rb  <= PROD_W'(i_in_blue)  * PROD_W'(SEP_RB);
            r_s1_gr  <= PROD_W'(i_in_red)   * PROD_W'(SEP_GR);
            r_s1_gg  <= PROD_W'(i_in_green) * PROD_W'(SEP_GG);
            r_s1_gb  <= PROD_W'(i_in_blue)  * PROD_W'(SEP_GB);
            r_s1_br  <= PROD_W'(i_in_red)   * PROD_W'(SEP_BR);
            r_s1_bg  <= PROD_W'(i_in_green) * PROD_W'(SEP_BG);
            r_s1_bb  <= PROD_W'(i_in_blue)  * PROD_W'(SEP_BB);
            r_s1_tri <= TRI_W'(i_in_red) + TRI_W'(i_in_green) + TRI_W'(i_in_blue);
            r_s1_max <= (in_max_rg > i_in_blue) ? in_max_rg : i_in_blue;
        end
    end

    // stage 2 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // mean by reciprocal multiply
    assign mean_prod = MEAN_PROD_W'(r_s1_tri) * MEAN_PROD_W'(RECIP3);

    // stage 2 payload: per-channel sums, mean and max
    always_ff @(posedge i_clk) begin
        if (adv_s2 && r_s1_valid) begin
            r_s2_pix   <= r_s1_pix;
            r_s2_eff   <= r_s1_eff;
            r_s2_sum_r <= SUM_W'(r_s1_rr) + SUM_W'(r_s1_rg) + SUM_W'(r_s1_rb);
            r_s2_sum_g <= SUM_W'(r_s1_gr) + SUM_W'(r_s1_gg) + SUM_W'(r_s1_gb);
            r_s2_sum_b <= SUM_W'(r_s1_br) + SUM_W'(r_s1_bg) + SUM_W'(r_s1_bb);
            r_s2_mean  <= mean_prod[RECIP_SHIFT +: CH_W];
            r_s2_max   <= r_s1_max;
        end
    end

    // drop the Q0.16 fraction and saturate at full scale
    assign sep_r_hi = r_s2_sum_r[SUM_W-1:COEF_W];
    assign sep_g_hi = r_s2_sum_g[SUM_W-1:COEF_W];
    assign sep_b_hi = r_s2_sum_b[SUM_W-1:COEF_W];
    assign sat_r    = (|sep_r_hi[SUM_W-COEF_W-1:CH_W]) ? '1 : sep_r_hi[CH_W-1:0];
    assign sat_g    = (|sep_g_hi[SUM_W-COEF_W-1:CH_W]) ? '1 : sep_g_hi[CH_W-1:0];
    assign sat_b    = (|sep_b_hi[SUM_W-COEF_W-1:CH_W]) ? '1 : sep_b_hi[CH_W-1:0];

    // effect select
    always_comb begin
        n_s3_pix = r_s2_pix;
        case (r_s2_eff)
            EFF_RED: begin
                n_s3_pix.green = '0;
                n_s3_pix.blue  = '0;
            end
            EFF_GREEN: begin
                n_s3_pix.red  = '0;
                n_s3_pix.blue = '0;
            end
            EFF_BLUE: begin
                n_s3_pix.red   = '0;
                n_s3_pix.green = '0;
            end
            EFF_MEAN: begin
                n_s3_pix.red   = r_s2_mean;
                n_s3_pix.green = r_s2_mean;
                n_s3_pix.blue  = r_s2_mean;
            end
            EFF_MAX: begin
                n_s3_pix.red   = r_s2_max;
                n_s3_pix.green = r_s2_max;
                n_s3_pix.blue  = r_s2_max;
            end
            EFF_SEPIA: begin
                n_s3_pix.red   = sat_r;
                n_s3_pix.green = sat_g;
                n_s3_pix.blue  = sat_b;
            end
            // unused codes pass the pixel through
            default: begin
                n_s3_pix = r_s2_pix;
            end
        endcase
    end

    // stage 3 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv_s3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    // stage 3 payload
    always_ff @(posedge i_clk) begin
        if (adv_s3 && r_s2_valid) begin
            r_s3_pix <= n_s3_pix;
        end
    end

    // output ports
    assign o_out_valid = r_s3_valid;
    assign o_out_red   = r_s3_pix.red;
    assign o_out_green = r_s3_pix.green;
    assign o_out_blue  = r_s3_pix.blue;
    assign o_out_last  = r_s3_pix.last;

endmodule
